// ===== rtl/sysex_frame_unpack_checksum_core_assert.svh =====
// Assertion macros shared by the frame unpacker modules.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SYSEX_FRAME_UNPACK_CHECKSUM_CORE_ASSERT_SVH
`define SYSEX_FRAME_UNPACK_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFUC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfuc_pkg.sv =====
// Shared types for the frame unpacker with 7-bit group decoding and checksum.
// No dependencies.
`timescale 1ns / 1ps

package sfuc_pkg;

    localparam int POS_W   = 8;
    localparam int SLOT_W  = 3;
    localparam int SUM_W   = 7;
    localparam int BYTE_W  = 8;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
        logic              frame_end;
        logic              checksum_ok;
    } t_result;

endpackage

// ===== rtl/sfuc_decode.sv =====
// Frame position tracking, 7-bit group decoding and checksum accumulation.
// Depends on sfuc_pkg and the assertion macro header.
`timescale 1ns / 1ps

module sfuc_decode #(
    parameter int FRAME_BYTES  = 155,
    parameter int HEADER_BYTES = 10,
    parameter int SUM_START    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [sfuc_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_push,
    output sfuc_pkg::t_result             o_result
);
    import sfuc_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CHK_POS   = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] SUM_POS   = POS_W'(SUM_START);

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [6:0]        r_msb,    n_msb;
    logic [SLOT_W-1:0] r_slot,   n_slot;
    logic [SUM_W-1:0]  r_sum,    n_sum;
    logic              r_passed, n_passed;

    logic [7:0]        msb_ext;
    logic              top_bit;

    assign msb_ext = {1'b0, r_msb};
    // Slot s takes bit (7 - s) of the MSB byte, which is the bitwise inverse of s.
    assign top_bit = msb_ext[~r_slot];

    always_comb begin
        n_pos    = r_pos;
        n_msb    = r_msb;
        n_slot   = r_slot;
        n_sum    = r_sum;
        n_passed = r_passed;
        o_push   = 1'b0;
        o_result = '0;
        if (i_accept) begin
            if (r_pos >= LAST_POS) begin
                o_push               = 1'b1;
                o_result.frame_end   = 1'b1;
                o_result.checksum_ok = r_passed;
                n_pos                = '0;
                n_msb                = '0;
                n_slot               = '0;
                n_sum                = '0;
            end else begin
                if (r_pos >= SUM_POS && r_pos <= CHK_POS) begin
                    n_sum = r_sum + i_byte[SUM_W-1:0];
                end
                if (r_pos == CHK_POS) begin
                    n_passed = (n_sum == '0);
                end
                n_pos = r_pos + 1'b1;
                if (r_pos >= HDR_POS && r_pos < CHK_POS) begin
                    if (r_slot == '0) begin
                        n_msb  = i_byte[6:0];
                        n_slot = SLOT_W'(1);
                    end else begin
                        o_push            = 1'b1;
                        o_result.out_byte = {i_byte[7] ^ top_bit, i_byte[6:0]};
                        o_result.is_data  = 1'b1;
                        n_slot            = (r_slot == '1) ? '0 : r_slot + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_msb    <= '0;
            r_slot   <= '0;
            r_sum    <= '0;
            r_passed <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_msb    <= n_msb;
            r_slot   <= n_slot;
            r_sum    <= n_sum;
            r_passed <= n_passed;
        end
    end

`include "sysex_frame_unpack_checksum_core_assert.svh"

    `SFUC_ASSERT_NOW(a_pos_in_frame, 1'b1, r_pos <= LAST_POS, "frame position past last byte")
    `SFUC_ASSERT_NEXT(a_frame_restart, i_accept && r_pos == LAST_POS,
        r_pos == '0 && r_slot == '0 && r_sum == '0, "frame state not cleared at frame end")
    `SFUC_ASSERT_NOW(a_data_in_payload, o_push && o_result.is_data,
        !o_result.frame_end && r_pos >= HDR_POS && r_pos < CHK_POS && r_slot != '0,
        "data item outside a group data slot")

endmodule

// ===== rtl/sfuc_out_stage.sv =====
// Output register with a skid entry so the input side keeps flowing during a stall.
// Depends on sfuc_pkg and the assertion macro header.
`timescale 1ns / 1ps

module sfuc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfuc_pkg::t_result   i_result,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output sfuc_pkg::t_result   o_result
);
    import sfuc_pkg::*;

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    pop;

    assign pop      = r_out_valid && i_ready;
    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // Input side is held off while the skid entry is occupied.
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

`include "sysex_frame_unpack_checksum_core_assert.svh"

    `SFUC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid entry held while output register empty")
    `SFUC_ASSERT_NEXT(a_skid_drains, r_skid_valid && pop,
        r_out_valid && !r_skid_valid, "skid entry not moved to output on pop")
    `SFUC_ASSERT_NEXT(a_push_lands, i_push && !r_skid_valid,
        r_out_valid, "pushed item not held in output stage")

endmodule

// ===== rtl/sysex_frame_unpack_checksum_core.sv =====
// A result item is registered in the output stage, in the output register or the skid entry.
// Throughput: one input item per cycle while o_ready is high; decode state updates per byte.
// A skid entry behind the output register keeps input flowing during a stall until a
// second result item is waiting.
// Reset (synchronous, active low) clears frame position, group, checksum and output valids.
// Framing restarts at reset: the first byte accepted afterward is byte 0 of a frame.
`timescale 1ns / 1ps

module sysex_frame_unpack_checksum_core #(
    parameter int FRAME_BYTES  = 155,
    parameter int HEADER_BYTES = 10,
    parameter int SUM_START    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sfuc_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sfuc_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_is_data,
    output logic                         o_frame_end,
    output logic                         o_checksum_ok
);
    import sfuc_pkg::*;

    logic    accept;
    logic    push;
    t_result dec_result;
    t_result out_result;

    assign accept = i_valid && o_ready;

    sfuc_decode #(
        .FRAME_BYTES  (FRAME_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .SUM_START    (SUM_START)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .o_push   (push),
        .o_result (dec_result)
    );

    sfuc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (dec_result),
        .o_space  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_out_byte    = out_result.out_byte;
    assign o_is_data     = out_result.is_data;
    assign o_frame_end   = out_result.frame_end;
    assign o_checksum_ok = out_result.checksum_ok;

endmodule

// ===== bench/sysex_unpack_checker.sv =====
// Scoreboard for the SysEx frame unpacker: predicts each result item from the accepted
// input bytes and compares it with what the block delivers. Depends on sfuc_pkg.
`timescale 1ns / 1ps

module sysex_unpack_checker #(
    parameter int FRAME_BYTES  = 155,
    parameter int HEADER_BYTES = 10,
    parameter int SUM_START    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [7:0] o_out_byte,
    input  logic       o_is_data,
    input  logic       o_frame_end,
    input  logic       o_checksum_ok,
    output int         fail_count,
    output int         pending_count
);
    import sfuc_pkg::*;

    t_result    expected_results[$];
    t_result    predicted;
    t_result    want;
    bit         has_result;

    logic [7:0] frame_pos;
    logic [6:0] msb_bits;
    logic [2:0] slot;
    logic [6:0] running_sum;
    logic       sum_good;

    task automatic decode_byte(input logic [7:0] b, output bit produced, output t_result r);
        logic top;
        r = '0;
        produced = 1'b0;
        top = 1'b0;
        if (frame_pos >= FRAME_BYTES - 1) begin
            // The last byte of a frame reports the verdict taken at the checksum byte.
            r.frame_end = 1'b1;
            r.checksum_ok = sum_good;
            produced = 1'b1;
            frame_pos = '0;
            msb_bits = '0;
            slot = '0;
            running_sum = '0;
        end else begin
            if (frame_pos >= SUM_START && frame_pos <= FRAME_BYTES - 2) begin
                running_sum = running_sum + b[6:0];
            end
            if (frame_pos == FRAME_BYTES - 2) begin
                sum_good = (running_sum == '0);
            end
            if (frame_pos >= HEADER_BYTES && frame_pos < FRAME_BYTES - 2) begin
                if (slot == '0) begin
                    msb_bits = b[6:0];
                    slot = 3'd1;
                end else begin
                    top = msb_bits[7 - slot];
                    r.out_byte = b + {top, 7'b0};
                    r.is_data = 1'b1;
                    produced = 1'b1;
                    slot = slot + 3'd1;
                end
            end
            frame_pos = frame_pos + 8'd1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = '0;
            msb_bits = '0;
            slot = '0;
            running_sum = '0;
            sum_good = 1'b0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            // Outputs are registered after their input, so check before predicting.
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: out_byte 8'h%02h", o_out_byte);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected 8'h%02h, got 8'h%02h",
                               want.out_byte, o_out_byte);
                        fail_count++;
                    end
                    if (o_is_data !== want.is_data) begin
                        $error("is_data: expected %b, got %b", want.is_data, o_is_data);
                        fail_count++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %b, got %b", want.frame_end, o_frame_end);
                        fail_count++;
                    end
                    if (o_checksum_ok !== want.checksum_ok) begin
                        $error("checksum_ok: expected %b, got %b",
                               want.checksum_ok, o_checksum_ok);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                decode_byte(i_in_byte, has_result, predicted);
                if (has_result) begin
                    expected_results = {expected_results, predicted};
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== bench/tb_sysex_frame_unpack_checksum_core.sv =====
// Top of the SysEx frame unpacker bench: drives whole frames with good and bad checksums
// under three idling patterns. Depends on sfuc_pkg, the core and sysex_unpack_checker.
`timescale 1ns / 1ps

module tb_sysex_frame_unpack_checksum_core;
    import sfuc_pkg::*;

    localparam int FRAME_BYTES   = 155;
    localparam int HEADER_BYTES  = 10;
    localparam int SUM_START     = 8;
    localparam int TAIL_BYTES    = 40;
    localparam int CYCLE_LIMIT   = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_in_byte = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_is_data;
    logic              o_frame_end;
    logic              o_checksum_ok;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          fail_count;
    int          pending_count;
    int unsigned cycle_count;

    // Two groups: every top bit set with MSB bit 7 clear, then no top bit with bit 7 set.
    logic [7:0] group_pattern [16] = '{
        8'h7f, 8'hff, 8'h00, 8'h7f, 8'h80, 8'h01, 8'hfe, 8'h55,
        8'h80, 8'hff, 8'h00, 8'h7f, 8'h80, 8'h01, 8'hfe, 8'haa
    };

    sysex_frame_unpack_checksum_core #(
        .FRAME_BYTES (FRAME_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .SUM_START   (SUM_START)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_frame_end  (o_frame_end),
        .o_checksum_ok(o_checksum_ok)
    );

    sysex_unpack_checker #(
        .FRAME_BYTES (FRAME_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .SUM_START   (SUM_START)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_frame_end  (o_frame_end),
        .o_checksum_ok(o_checksum_ok),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_frame(input bit lead_pattern, input bit sum_right);
        logic [6:0] sum7;
        logic [6:0] fix;
        logic [7:0] b;
        sum7 = '0;
        for (int pos = 0; pos < FRAME_BYTES; pos++) begin
            b = 8'($urandom);
            if (lead_pattern && pos < HEADER_BYTES) begin
                b = pos[0] ? 8'hff : 8'h00;
            end
            if (lead_pattern && pos >= HEADER_BYTES && pos < HEADER_BYTES + 16) begin
                b = group_pattern[pos - HEADER_BYTES];
            end
            if (pos == FRAME_BYTES - 2) begin
                // Bit 7 of the checksum byte stays random; only the low seven bits count.
                fix = 7'd0 - sum7;
                if (!sum_right) begin
                    fix = fix + 7'($urandom_range(1, 127));
                end
                b = {b[7], fix};
            end
            if (pos >= SUM_START && pos < FRAME_BYTES - 2) begin
                sum7 = sum7 + b[6:0];
            end
            send_byte(b);
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        send_idle = 26;
        recv_idle = 53;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(1'b1, 1'b1);

        send_idle = 53;
        recv_idle = 26;
        send_frame(1'b0, 1'b0);

        send_idle = 0;
        recv_idle = 0;
        send_frame(1'b0, $urandom_range(3) != 0);
        // A trailing partial frame of raw bytes.
        repeat (TAIL_BYTES) send_byte(8'($urandom));
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending_count != 0);
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
